@@ rtl/sgb_pkg.sv @@
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared constants, tap weight tables and helper functions for the
// separable Gaussian blur unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sgb_pkg;

  localparam int PIX_W      = 8;
  localparam int WT_W       = 7;
  localparam int CFG_W      = 12;
  localparam int DIM_W      = 13;
  localparam int COORD_W    = 11;
  localparam int FIFO_DEPTH = 16;
  // register stages inside one tap-sum-and-divide unit
  localparam int FIR_LAT    = 5;

  // register select, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [WT_W-1:0] WT3 [4] = '{7'd99, 7'd68, 7'd35, 7'd10};
  localparam logic [WT_W-1:0] WT4 [5] = '{7'd99, 7'd82, 7'd46, 7'd18, 7'd5};
  localparam logic [WT_W-1:0] WT5 [6] = '{7'd99, 7'd88, 7'd61, 7'd33, 7'd14, 7'd5};
  localparam logic [WT_W-1:0] WT6 [7] = '{7'd99, 7'd91, 7'd70, 7'd46, 7'd25, 7'd12,
                                          7'd5};
  localparam logic [WT_W-1:0] WT7 [8] = '{7'd99, 7'd93, 7'd77, 7'd56, 7'd36, 7'd21,
                                          7'd10, 7'd5};
  localparam logic [WT_W-1:0] WT8 [9] = '{7'd99, 7'd95, 7'd82, 7'd64, 7'd46, 7'd30,
                                          7'd18, 7'd10, 7'd5};
  localparam logic [WT_W-1:0] WT32 [33] = '{
    7'd99, 7'd99, 7'd98, 7'd97, 7'd95, 7'd92, 7'd89, 7'd86, 7'd82, 7'd78, 7'd73,
    7'd69, 7'd64, 7'd60, 7'd55, 7'd50, 7'd46, 7'd41, 7'd37, 7'd33, 7'd30, 7'd26,
    7'd23, 7'd20, 7'd18, 7'd15, 7'd13, 7'd11, 7'd10, 7'd8, 7'd7, 7'd6, 7'd5};
  localparam logic [WT_W-1:0] WT64 [65] = '{
    7'd99, 7'd99, 7'd99, 7'd99, 7'd98, 7'd98, 7'd97, 7'd96, 7'd95, 7'd94, 7'd92,
    7'd91, 7'd89, 7'd88, 7'd86, 7'd84, 7'd82, 7'd80, 7'd78, 7'd76, 7'd73, 7'd71,
    7'd69, 7'd67, 7'd64, 7'd62, 7'd60, 7'd57, 7'd55, 7'd53, 7'd50, 7'd48, 7'd46,
    7'd44, 7'd41, 7'd39, 7'd37, 7'd35, 7'd33, 7'd32, 7'd30, 7'd28, 7'd26, 7'd25,
    7'd23, 7'd22, 7'd20, 7'd19, 7'd18, 7'd16, 7'd15, 7'd14, 7'd13, 7'd12, 7'd11,
    7'd10, 7'd10, 7'd9, 7'd8, 7'd7, 7'd7, 7'd6, 7'd6, 7'd5, 7'd5};

  // weight of a tap at distance k from the center; past the table end the
  // last weight repeats
  function automatic logic [WT_W-1:0] tap_weight(input int half, input int k);
    logic [WT_W-1:0] w;
    if (half <= 3)       w = WT3[(k < 4) ? k : 3];
    else if (half == 4)  w = WT4[(k < 5) ? k : 4];
    else if (half == 5)  w = WT5[(k < 6) ? k : 5];
    else if (half == 6)  w = WT6[(k < 7) ? k : 6];
    else if (half == 7)  w = WT7[(k < 8) ? k : 7];
    else if (half == 8)  w = WT8[(k < 9) ? k : 8];
    else if (half <= 32) w = WT32[(k < 33) ? k : 32];
    else                 w = WT64[(k < 65) ? k : 64];
    return w;
  endfunction

  function automatic int tap_dist(input int half, input int j);
    return (j >= half) ? (j - half) : (half - j);
  endfunction

  function automatic int tap_total(input int half);
    int s;
    s = 0;
    for (int j = 0; j < 2 * half + 1; j++) begin
      s = s + int'(tap_weight(half, tap_dist(half, j)));
    end
    return (s == 0) ? 1 : s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sgb_ram.sv @@
// ----------------------------------------------------------------------------
// sgb_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/sgb_fir_div.sv @@
// ----------------------------------------------------------------------------
// sgb_fir_div
// Weighted sum of 2*HALF_TAPS+1 pixel taps followed by truncating division
// by the tap total; fixed five-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_fir_div #(
  parameter int HALF_TAPS = 32,
  localparam int TAPS = 2 * HALF_TAPS + 1
) (
  input  wire logic                     clk,
  input  wire logic [sgb_pkg::PIX_W-1:0] taps [TAPS],
  output logic      [sgb_pkg::PIX_W-1:0] quo
);

  localparam int    TOTAL = sgb_pkg::tap_total(HALF_TAPS);
  localparam int    SUM_W = sgb_pkg::PIX_W + $clog2(TOTAL + 1);
  localparam int    NG    = (TAPS + 7) / 8;
  localparam int    PW    = 2 * SUM_W;
  localparam longint RECIP = (64'd1 << SUM_W) / TOTAL;

  logic [SUM_W-1:0]          grp_nxt [NG];
  logic [SUM_W-1:0]          grp_r   [NG];
  logic [SUM_W-1:0]          sum_nxt;
  logic [SUM_W-1:0]          sum_r;
  logic [PW-1:0]             prod_r;
  logic [SUM_W-1:0]          sum_d1_r;
  logic [sgb_pkg::PIX_W-1:0] qest_r;
  logic [SUM_W-1:0]          sum_d2_r;
  logic [SUM_W-1:0]          rem;
  logic [sgb_pkg::PIX_W-1:0] quo_nxt;
  logic [sgb_pkg::PIX_W-1:0] quo_r;

  // groups of eight taps, constant weights
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int i = 0; i < 8; i++) begin
        if (g * 8 + i < TAPS) begin
          grp_nxt[g] = grp_nxt[g]
            + SUM_W'(taps[(g * 8 + i < TAPS) ? g * 8 + i : TAPS - 1])
            * SUM_W'(sgb_pkg::tap_weight(HALF_TAPS,
                                          sgb_pkg::tap_dist(HALF_TAPS, g * 8 + i)));
        end
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      sum_nxt = sum_nxt + grp_r[g];
    end
  end

  // reciprocal estimate is exact or one low; one compare fixes it
  assign rem     = sum_d2_r - SUM_W'(qest_r) * SUM_W'(TOTAL);
  assign quo_nxt = (rem >= SUM_W'(TOTAL)) ? qest_r + 1'b1 : qest_r;

  always_ff @(posedge clk) begin
    grp_r    <= grp_nxt;
    sum_r    <= sum_nxt;
    prod_r   <= PW'(sum_r) * PW'(RECIP);
    sum_d1_r <= sum_r;
    qest_r   <= prod_r[SUM_W +: sgb_pkg::PIX_W];
    sum_d2_r <= sum_d1_r;
    quo_r    <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

`default_nettype wire

@@ rtl/sgb_out_fifo.sv @@
// ----------------------------------------------------------------------------
// sgb_out_fifo
// Small result queue in front of the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_out_fifo #(
  parameter int W     = 32,
  parameter int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [W-1:0]     push_data,
  input  wire logic             ready,
  output logic                  valid,
  output logic      [W-1:0]     data,
  output logic      [CNT_W-1:0] count
);

  logic [W-1:0]     mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;

  assign valid = (cnt_r != '0);
  assign pop   = valid && ready;
  assign data  = mem_r[rptr_r];
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

@@ rtl/separable_gaussian_blur_unit.sv @@
// ----------------------------------------------------------------------------
// separable_gaussian_blur_unit
// Raster-stream separable Gaussian blur: row pass over a pixel shift line,
// column pass over a line store holding every line slot of a column.
// ----------------------------------------------------------------------------
// Path: an accepted beat runs through the pixel shift line, the row pass, the
//   line store read-modify-write, the column pass and the result queue, and
//   its result beat then shows on out_.
// Throughput: one pixel beat per cycle while in_tready is high; the line store
//   does one read and one write of a whole column entry per row result.
// Reset: clears position, control pipeline and queue; width and height
//   return to MAX_WIDTH / MAX_HEIGHT. The line store is not cleared.
`default_nettype none

module separable_gaussian_blur_unit #(
  parameter int HALF_TAPS  = 32,
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  // pixel input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] pixel
  input  wire logic        in_tuser,   // [0] frame_start
  // result output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata   // [10:0] out_col, [21:11] out_row,
                                       // [29:22] blurred_value, [31:30] zero
);

  localparam int TAPS   = 2 * HALF_TAPS + 1;
  localparam int LINES  = 2 * HALF_TAPS;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int SW     = $clog2(LINES);
  localparam int PW8    = sgb_pkg::PIX_W;
  localparam int MEM_W  = LINES * PW8;
  localparam int DW     = sgb_pkg::DIM_W;
  localparam int RD_ST  = sgb_pkg::FIR_LAT - 1;
  localparam int WR_ST  = sgb_pkg::FIR_LAT;
  localparam int PIPE   = 2 * sgb_pkg::FIR_LAT + 2;
  localparam int OUT_ST = PIPE - 1;
  localparam int RES_W  = 2 * sgb_pkg::COORD_W + PW8;
  localparam int CNT_W  = $clog2(sgb_pkg::FIFO_DEPTH + 1);

  typedef struct packed {
    logic          hv;      // row pass result exists for this beat
    logic          emit;    // beat produces a result
    logic          rv_en;   // row result is not a border row
    logic [CW-1:0] col;     // center column
    logic [RW-1:0] row;     // output row
    logic [SW-1:0] slot;    // line slot of the current row
  } ctl_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [DW-1:0] width_r, height_r;
  logic [DW-1:0] w_eff, h_eff;
  logic          cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DW'(MAX_WIDTH);
      height_r <= DW'(MAX_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_paddr[2])
        sgb_pkg::REG_WIDTH:  width_r  <= DW'(cfg_pwdata[sgb_pkg::CFG_W-1:0]);
        sgb_pkg::REG_HEIGHT: height_r <= DW'(cfg_pwdata[sgb_pkg::CFG_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      sgb_pkg::REG_WIDTH:  cfg_prdata = 32'(width_r);
      sgb_pkg::REG_HEIGHT: cfg_prdata = 32'(height_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // clamp to 1..MAX
  assign w_eff = (width_r == '0) ? DW'(1) :
                 (width_r > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r == '0) ? DW'(1) :
                 (height_r > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : height_r;

  // ---------------------------------------------------------------------------
  // raster position
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_r, col_nxt, col_cur;
  logic [RW-1:0] row_r, row_nxt, row_cur;
  logic [SW-1:0] slot_r, slot_nxt, slot_cur;
  logic [DW-1:0] col_inc, row_inc;
  logic          accept;
  ctl_t          ctl_in;
  ctl_t          ctl_r [PIPE];

  logic [CNT_W-1:0] pend_r;
  logic [CNT_W-1:0] fifo_cnt;

  assign in_tready = (CNT_W'(1) + pend_r + fifo_cnt) <= CNT_W'(sgb_pkg::FIFO_DEPTH);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    // restart a coordinate on frame start or when it lies past the frame
    col_cur  = (in_tuser || DW'(col_r) >= w_eff) ? '0 : col_r;
    row_cur  = (in_tuser || DW'(row_r) >= h_eff) ? '0 : row_r;
    slot_cur = (in_tuser || DW'(row_r) >= h_eff) ? '0 : slot_r;

    ctl_in.hv    = DW'(col_cur) >= DW'(LINES);
    ctl_in.emit  = ctl_in.hv && (DW'(row_cur) >= DW'(LINES));
    ctl_in.rv_en = (DW'(row_cur) >= DW'(HALF_TAPS))
                && (DW'(row_cur) + DW'(HALF_TAPS + 1) <= h_eff);
    ctl_in.col   = col_cur - CW'(HALF_TAPS);
    ctl_in.row   = row_cur - RW'(HALF_TAPS);
    ctl_in.slot  = slot_cur;

    col_inc  = DW'(col_cur) + DW'(1);
    row_inc  = DW'(row_cur) + DW'(1);
    col_nxt  = CW'(col_inc);
    row_nxt  = row_cur;
    slot_nxt = slot_cur;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      if (row_inc >= h_eff) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = RW'(row_inc);
        slot_nxt = (slot_cur == SW'(LINES - 1)) ? '0 : slot_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  // control pipeline: advances every cycle, empty slots carry no flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE; k++) ctl_r[k] <= '0;
    end else begin
      ctl_r[0] <= accept ? ctl_in : '0;
      for (int k = 1; k < PIPE; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // row pass: pixel shift line feeding the tap sum
  // ---------------------------------------------------------------------------
  logic [PW8-1:0] window_r [TAPS];
  logic [PW8-1:0] h_quo;

  always_ff @(posedge clk) begin
    if (accept) begin
      window_r[0] <= in_tdata;
      for (int j = 1; j < TAPS; j++) window_r[j] <= window_r[j-1];
    end
  end

  sgb_fir_div #(.HALF_TAPS(HALF_TAPS)) u_row_pass (
    .clk  (clk),
    .taps (window_r),
    .quo  (h_quo)
  );

  // ---------------------------------------------------------------------------
  // line store: entry per column, one byte per line slot. Read the entry in the
  // cycle before, insert the new row result into its slot and write it back.
  // The same column comes back only a full row later, so accesses never meet.
  // ---------------------------------------------------------------------------
  logic [MEM_W-1:0] line_rd, line_wr;
  logic [PW8-1:0]   rv;
  logic [PW8-1:0]   rot_nxt [LINES];
  logic [PW8-1:0]   rot_r   [LINES];
  logic [PW8-1:0]   rv_r;
  logic [PW8-1:0]   vtaps   [TAPS];
  logic [PW8-1:0]   v_quo;

  assign rv = ctl_r[WR_ST].rv_en ? h_quo : '0;

  always_comb begin
    for (int s = 0; s < LINES; s++) begin
      line_wr[s*PW8 +: PW8] = (SW'(s) == ctl_r[WR_ST].slot) ? rv : line_rd[s*PW8 +: PW8];
    end
  end

  // rotate so that tap j holds slot (current slot + j) mod LINES
  always_comb begin
    logic [SW:0] idx;
    for (int j = 0; j < LINES; j++) begin
      idx = {1'b0, ctl_r[WR_ST].slot} + (SW+1)'(j);
      if (idx >= (SW+1)'(LINES)) idx = idx - (SW+1)'(LINES);
      rot_nxt[j] = line_rd[idx[SW-1:0]*PW8 +: PW8];
    end
  end

  sgb_ram #(.WIDTH(MEM_W), .DEPTH(MAX_WIDTH)) u_line_store (
    .clk   (clk),
    .we    (ctl_r[WR_ST].hv),
    .waddr (ctl_r[WR_ST].col),
    .wdata (line_wr),
    .re    (ctl_r[RD_ST].hv),
    .raddr (ctl_r[RD_ST].col),
    .rdata (line_rd)
  );

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
    rv_r  <= rv;
  end

  // ---------------------------------------------------------------------------
  // column pass: older line slots plus the fresh row result as bottom tap
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int j = 0; j < LINES; j++) vtaps[j] = rot_r[j];
    vtaps[LINES] = rv_r;
  end

  sgb_fir_div #(.HALF_TAPS(HALF_TAPS)) u_col_pass (
    .clk  (clk),
    .taps (vtaps),
    .quo  (v_quo)
  );

  // ---------------------------------------------------------------------------
  // result queue; ready counts queued plus in-flight results, so the
  // pipeline never has to stall
  // ---------------------------------------------------------------------------
  logic             push;
  logic [RES_W-1:0] push_data;
  logic [RES_W-1:0] pop_data;

  assign push      = ctl_r[OUT_ST].emit;
  assign push_data = {v_quo,
                      sgb_pkg::COORD_W'(ctl_r[OUT_ST].row),
                      sgb_pkg::COORD_W'(ctl_r[OUT_ST].col)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + CNT_W'(accept && ctl_in.emit) - CNT_W'(push);
    end
  end

  sgb_out_fifo #(.W(RES_W), .DEPTH(sgb_pkg::FIFO_DEPTH)) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .ready     (out_tready),
    .valid     (out_tvalid),
    .data      (pop_data),
    .count     (fifo_cnt)
  );

  assign out_tdata = 32'(pop_data);

`ifndef SYNTH
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+1)'(pend_r) + (CNT_W+1)'(fifo_cnt) <= (CNT_W+1)'(sgb_pkg::FIFO_DEPTH))
    else $error("pending plus queued results exceed queue depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> fifo_cnt < CNT_W'(sgb_pkg::FIFO_DEPTH))
    else $error("result pushed into a full queue");

  a_line_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl_r[WR_ST].hv && ctl_r[RD_ST].hv && ctl_r[WR_ST].col == ctl_r[RD_ST].col))
    else $error("line store read and write hit the same column");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser) |=> (row_r == '0 || row_r == RW'(1)))
    else $error("frame start did not restart the row position");
`endif

endmodule

`default_nettype wire
